FILE: hw/rtl/apn_pkg.sv
// apn_pkg: shared types and constants of the absolute path normalizer
// request/result structs, character codes and status codes
// no dependencies
package apn_pkg;

  // character codes
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharNul   = 8'h00;

  // request kinds
  localparam logic ReqPush = 1'b0;
  localparam logic ReqRead = 1'b1;

  // status codes (also the sticky error codes)
  localparam logic [1:0] StBusy    = 2'd0;
  localparam logic [1:0] StDone    = 2'd1;
  localparam logic [1:0] StNotAbs  = 2'd2;
  localparam logic [1:0] StTooLong = 2'd3;

  // component dot counter: 0..2 pending dots, 3 once the component is stored
  localparam logic [1:0] DotsStored = 2'd3;

  // one input item
  typedef struct packed {
    logic       req_type;
    logic [7:0] path_byte;
    logic       end_of_path;
    logic [7:0] read_index;
  } req_t;

  // one result item
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] norm_length;
    logic [7:0] read_data;
  } rsp_t;

endpackage

FILE: hw/rtl/apn_req_if.sv
// apn_req_if: request channel of the path normalizer
// valid/ready handshake with the input item fields, no dependencies
interface apn_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] path_byte;
  logic       end_of_path;
  logic [7:0] read_index;

  modport source (output valid, output req_type, output path_byte, output end_of_path,
                  output read_index, input ready);
  modport sink   (input valid, input req_type, input path_byte, input end_of_path,
                  input read_index, output ready);
endinterface

FILE: hw/rtl/apn_rsp_if.sv
// apn_rsp_if: result channel of the path normalizer
// valid/ready handshake with the result item fields, no dependencies
interface apn_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] norm_length;
  logic [7:0] read_data;

  modport source (output valid, output status, output norm_length, output read_data,
                  input ready);
  modport sink   (input valid, input status, input norm_length, input read_data,
                  output ready);
endinterface

FILE: hw/rtl/apn_cfg_if.sv
// apn_cfg_if: configuration write channel of the path normalizer
// carries the capacity register write data, no dependencies
interface apn_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] capacity_bytes;

  modport source (output valid, output capacity_bytes, input ready);
  modport sink   (input valid, input capacity_bytes, output ready);
endinterface

FILE: hw/rtl/apn_ram.sv
// apn_ram: generic single write port, single read port RAM
// read data is registered and holds while read enable is low; no dependencies
module apn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: hw/rtl/apn_core.sv
// apn_core: sequencer of the path normalizer around the byte store
// depends on apn_pkg and apn_ram; one item at a time, store writes and
// walk-back reads go one byte per step through the single RAM port pair
module apn_core #(
  parameter int unsigned BUF_BYTES = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  apn_pkg::req_t req_i,
  input  logic [8:0]    cap_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output apn_pkg::rsp_t rsp_o
);

  localparam int unsigned AW = $clog2(BUF_BYTES);
  localparam int unsigned LW = AW + 1;
  localparam int unsigned CW = (LW + 2 > 9) ? LW + 2 : 9;
  localparam logic [CW-1:0] BufC = CW'(BUF_BYTES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT,
    S_WALK_RD,
    S_WALK_CHK,
    S_FIN
  } state_e;

  state_e        state_q, state_d;
  logic [LW-1:0] len_q, len_d;
  logic [1:0]    dots_q, dots_d;
  logic [1:0]    err_q, err_d;
  logic          fbs_q, fbs_d;
  logic          pend_slash_q, pend_slash_d;
  logic [1:0]    pend_dots_q, pend_dots_d;
  logic [7:0]    char_q, char_d;
  logic          rd_hit_q, rd_hit_d;
  logic          rd_root_q, rd_root_d;

  // store port
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  // push decode
  logic [7:0]    c;
  logic          eop;
  logic [CW-1:0] cap_c, eff_cap;
  logic          start, s_fbs, take, sep;
  logic [1:0]    s_err, s_dots;
  logic [LW-1:0] s_len;
  logic [CW-1:0] s_len_c, need_c;
  logic [1:0]    t_err, t_dots, t_pdots, after_dots, f_dots;
  logic          t_emit, t_slash, t_close, e_close, walk;
  logic [LW-1:0] len_m1;
  logic [AW+7:0] idx_w;
  logic [LW+7:0] len_ext;

  assign c       = req_i.path_byte;
  assign eop     = req_i.end_of_path;
  assign cap_c   = CW'(cap_i);
  assign eff_cap = (cap_c > BufC) ? BufC : cap_c;
  assign len_m1  = len_q - LW'(1);
  assign idx_w   = {{AW{1'b0}}, req_i.read_index};
  assign len_ext = {8'h00, len_q};

  // path start, byte handling and end-mark close for a push item
  always_comb begin
    start   = !fbs_q && ((c != apn_pkg::CharNul) || eop);
    s_fbs   = fbs_q | start;
    s_len   = start ? LW'(1) : len_q;
    s_dots  = start ? 2'd0 : dots_q;
    if (start) begin
      if (cap_c < CW'(2)) begin
        s_err = apn_pkg::StTooLong;
      end else if (c != apn_pkg::CharSlash) begin
        s_err = apn_pkg::StNotAbs;
      end else begin
        s_err = apn_pkg::StBusy;
      end
    end else begin
      s_err = err_q;
    end
    s_len_c = CW'(s_len);
    sep     = (s_len > LW'(1));
    need_c  = s_len_c + CW'(sep) + CW'(s_dots) + CW'(2);
    take    = s_fbs && (s_err == apn_pkg::StBusy) && (c != apn_pkg::CharNul);
    t_err   = s_err;
    t_dots  = s_dots;
    t_emit  = 1'b0;
    t_slash = 1'b0;
    t_pdots = 2'd0;
    t_close = 1'b0;
    if (take) begin
      if (c == apn_pkg::CharSlash) begin
        t_close = 1'b1;
      end else if (s_dots == apn_pkg::DotsStored) begin
        if (s_len_c + CW'(2) > eff_cap) begin
          t_err = apn_pkg::StTooLong;
        end else begin
          t_emit = 1'b1;
        end
      end else if ((c == apn_pkg::CharDot) && (s_dots != 2'd2)) begin
        t_dots = s_dots + 2'd1;
      end else if (need_c > eff_cap) begin
        t_err = apn_pkg::StTooLong;
      end else begin
        t_emit  = 1'b1;
        t_slash = sep;
        t_pdots = s_dots;
        t_dots  = apn_pkg::DotsStored;
      end
    end
    after_dots = t_close ? 2'd0 : t_dots;
    e_close    = eop && s_fbs && (t_err == apn_pkg::StBusy);
    walk       = (t_close && (s_dots == 2'd2)) || (e_close && (after_dots == 2'd2));
    f_dots     = (t_close || e_close) ? 2'd0 : t_dots;
  end

  // sequencer next state
  always_comb begin
    state_d      = state_q;
    len_d        = len_q;
    dots_d       = dots_q;
    err_d        = err_q;
    fbs_d        = fbs_q;
    pend_slash_d = pend_slash_q;
    pend_dots_d  = pend_dots_q;
    char_d       = char_q;
    rd_hit_d     = rd_hit_q;
    rd_root_d    = rd_root_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = len_q[AW-1:0];
    ram_raddr    = len_m1[AW-1:0];
    ram_wdata    = char_q;
    req_ready_o  = (state_q == S_IDLE);
    rsp_valid_o  = (state_q == S_FIN);
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          if (req_i.req_type == apn_pkg::ReqRead) begin
            ram_re    = 1'b1;
            ram_raddr = idx_w[AW-1:0];
            rd_root_d = (req_i.read_index == 8'd0);
            rd_hit_d  = (CW'(req_i.read_index) < CW'(len_q));
            state_d   = S_FIN;
          end else begin
            rd_root_d    = 1'b0;
            rd_hit_d     = 1'b0;
            err_d        = t_err;
            len_d        = s_len;
            dots_d       = f_dots;
            fbs_d        = s_fbs && !eop;
            pend_slash_d = t_slash;
            pend_dots_d  = t_pdots;
            char_d       = c;
            if (t_emit) begin
              state_d = S_EMIT;
            end else if (walk) begin
              state_d = S_WALK_RD;
            end else begin
              state_d = S_FIN;
            end
          end
        end
      end
      // one stored byte per cycle: separator, pending dots, then the byte
      S_EMIT: begin
        ram_we = 1'b1;
        len_d  = len_q + LW'(1);
        if (pend_slash_q) begin
          ram_wdata    = apn_pkg::CharSlash;
          pend_slash_d = 1'b0;
        end else if (pend_dots_q != 2'd0) begin
          ram_wdata   = apn_pkg::CharDot;
          pend_dots_d = pend_dots_q - 2'd1;
        end else begin
          ram_wdata = char_q;
          state_d   = S_FIN;
        end
      end
      // walk back over the last component, never above the root
      S_WALK_RD: begin
        if (len_q > LW'(1)) begin
          ram_re  = 1'b1;
          state_d = S_WALK_CHK;
        end else begin
          state_d = S_FIN;
        end
      end
      S_WALK_CHK: begin
        len_d   = len_m1;
        state_d = (ram_rdata == apn_pkg::CharSlash) ? S_FIN : S_WALK_RD;
      end
      S_FIN: begin
        if (rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      len_q        <= LW'(1);
      dots_q       <= 2'd0;
      err_q        <= apn_pkg::StBusy;
      fbs_q        <= 1'b0;
      pend_slash_q <= 1'b0;
      pend_dots_q  <= 2'd0;
      char_q       <= 8'h00;
      rd_hit_q     <= 1'b0;
      rd_root_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      len_q        <= len_d;
      dots_q       <= dots_d;
      err_q        <= err_d;
      fbs_q        <= fbs_d;
      pend_slash_q <= pend_slash_d;
      pend_dots_q  <= pend_dots_d;
      char_q       <= char_d;
      rd_hit_q     <= rd_hit_d;
      rd_root_q    <= rd_root_d;
    end
  end

  // result fields; entry 0 always holds the root slash
  always_comb begin
    if (err_q != apn_pkg::StBusy) begin
      rsp_o.status = err_q;
    end else begin
      rsp_o.status = fbs_q ? apn_pkg::StBusy : apn_pkg::StDone;
    end
    rsp_o.norm_length = len_ext[7:0];
    if (rd_root_q) begin
      rsp_o.read_data = apn_pkg::CharSlash;
    end else if (rd_hit_q) begin
      rsp_o.read_data = ram_rdata;
    end else begin
      rsp_o.read_data = apn_pkg::CharNul;
    end
  end

  // byte store
  apn_ram #(
    .WIDTH(8),
    .DEPTH(BUF_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // length stays inside the store and never drops below the root
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q != LW'(0)) && (len_q < LW'(BUF_BYTES)))
    else $error("stored length out of range");

  // every walk-back check removes exactly one byte
  a_walk_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK_CHK) |=> (len_q == $past(len_q) - LW'(1)))
    else $error("walk-back step did not shorten the path by one");

  // writes leave room for the terminator under the capacity in use
  a_emit_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (CW'(len_q) + CW'(2) <= eff_cap))
    else $error("store write beyond capacity");

endmodule

FILE: hw/rtl/absolute_path_normalizer.sv
// absolute_path_normalizer: top level of the path normalizer
// depends on apn_pkg, apn_req_if, apn_rsp_if, apn_cfg_if and apn_core
//
//   channel   dir   payload                                          transfer
//   req_if    in    req_type, path_byte, end_of_path, read_index     valid & ready
//   rsp_if    out   status, norm_length, read_data                   valid & ready
//   cfg_if    in    capacity_bytes                                   valid & ready
//
// reads and plain push bytes: accept, finish state, then the result in the output register
// a push that stores bytes writes them one per cycle (up to 4), one store write port
// a '..' walk-back scans each stored byte through a read state and a check state (registered store read)
// req_if is ready only while the sequencer is idle; a held result stalls the next finish
// reset needs no clearing pass: length 1 and the root slash are implied, cfg is always ready
module absolute_path_normalizer #(
  parameter int unsigned BUF_BYTES = 256
) (
  input logic        clk_i,
  input logic        rst_ni,
  apn_req_if.sink    req_if,
  apn_rsp_if.source  rsp_if,
  apn_cfg_if.sink    cfg_if
);

  logic [8:0]    cap_q;
  apn_pkg::req_t core_req;
  apn_pkg::rsp_t core_rsp, out_q;
  logic          core_rsp_valid, core_rsp_ready;
  logic          out_valid_q;

  // capacity register, written on a cfg transfer
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 9'd256;
    end else if (cfg_if.valid) begin
      cap_q <= cfg_if.capacity_bytes;
    end
  end

  // request pack
  assign core_req.req_type    = req_if.req_type;
  assign core_req.path_byte   = req_if.path_byte;
  assign core_req.end_of_path = req_if.end_of_path;
  assign core_req.read_index  = req_if.read_index;

  apn_core #(
    .BUF_BYTES(BUF_BYTES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_if.valid),
    .req_ready_o(req_if.ready),
    .req_i      (core_req),
    .cap_i      (cap_q),
    .rsp_valid_o(core_rsp_valid),
    .rsp_ready_i(core_rsp_ready),
    .rsp_o      (core_rsp)
  );

  // output register
  assign core_rsp_ready = !out_valid_q || rsp_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_rsp_valid && core_rsp_ready) begin
      out_valid_q <= 1'b1;
    end else if (rsp_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_rsp_valid && core_rsp_ready) begin
      out_q <= core_rsp;
    end
  end

  assign rsp_if.valid       = out_valid_q;
  assign rsp_if.status      = out_q.status;
  assign rsp_if.norm_length = out_q.norm_length;
  assign rsp_if.read_data   = out_q.read_data;

endmodule

FILE: bench/apn_checker.sv
// apn_checker: scoreboard for the absolute path normalizer
// watches the request, result and capacity channels, predicts each result and compares it
// depends on apn_pkg, apn_req_if, apn_rsp_if and apn_cfg_if
module apn_checker #(
  parameter int unsigned BUF_BYTES = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  apn_req_if   req_if,
  apn_rsp_if   rsp_if,
  apn_cfg_if   cfg_if,
  output int   fail_count_o,
  output int   outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LenW = $clog2(BUF_BYTES + 1);
  localparam logic [1:0] ErrNone = 2'd0;

  // mirrored state of the normalizer
  logic [7:0]      norm_bytes [BUF_BYTES];
  logic [LenW-1:0] norm_len;
  logic [1:0]      comp_dots;
  logic [1:0]      err_code;
  logic            in_path;
  logic [8:0]      capacity;

  apn_pkg::rsp_t awaited_q [$];
  apn_pkg::rsp_t want;
  apn_pkg::req_t item;
  int            mismatches;

  function automatic int unsigned usable_capacity();
    return (capacity > BUF_BYTES) ? BUF_BYTES : int'(capacity);
  endfunction

  function automatic void append_byte(logic [7:0] b);
    if (norm_len < BUF_BYTES) begin
      norm_bytes[norm_len] = b;
      norm_len = norm_len + 1'b1;
    end
  endfunction

  // end of a component: a pending '..' walks back over one stored component
  function automatic void close_component();
    if (comp_dots == 2'd2) begin
      while (norm_len > 1 && norm_bytes[norm_len - 1] != apn_pkg::CharSlash)
        norm_len = norm_len - 1'b1;
      if (norm_len > 1) norm_len = norm_len - 1'b1;
    end
    comp_dots = 2'd0;
  endfunction

  // one path character while no error is pending
  function automatic void take_char(logic [7:0] c);
    int unsigned room;
    int unsigned need;
    room = usable_capacity();
    if (c == apn_pkg::CharSlash) begin
      close_component();
      return;
    end
    if (comp_dots == apn_pkg::DotsStored) begin
      if (norm_len + 2 > room) err_code = apn_pkg::StTooLong;
      else append_byte(c);
      return;
    end
    if (c == apn_pkg::CharDot && comp_dots < 2'd2) begin
      comp_dots++;
      return;
    end
    // first real character: separator, held dots, then the character
    need = ((norm_len > 1) ? 2 : 1) + comp_dots;
    if (norm_len + need + 1 > room) begin
      err_code = apn_pkg::StTooLong;
      return;
    end
    if (norm_len > 1) append_byte(apn_pkg::CharSlash);
    repeat (comp_dots) append_byte(apn_pkg::CharDot);
    append_byte(c);
    comp_dots = apn_pkg::DotsStored;
  endfunction

  function automatic void start_path();
    err_code      = ErrNone;
    norm_len      = 1;
    norm_bytes[0] = apn_pkg::CharSlash;
    comp_dots     = 2'd0;
    in_path       = 1'b1;
    if (usable_capacity() < 2) err_code = apn_pkg::StTooLong;
  endfunction

  // advances the mirrored state by one item and returns its result
  function automatic apn_pkg::rsp_t normalize_item(apn_pkg::req_t it);
    apn_pkg::rsp_t r;
    r = '0;
    if (it.req_type == apn_pkg::ReqRead) begin
      if (it.read_index < norm_len) r.read_data = norm_bytes[it.read_index];
    end else begin
      if (!in_path) begin
        if (it.path_byte != apn_pkg::CharNul) begin
          start_path();
          if (err_code == ErrNone && it.path_byte != apn_pkg::CharSlash)
            err_code = apn_pkg::StNotAbs;
        end else if (it.end_of_path) begin
          // empty path
          start_path();
          if (err_code == ErrNone) err_code = apn_pkg::StNotAbs;
        end
      end
      if (in_path && err_code == ErrNone && it.path_byte != apn_pkg::CharNul)
        take_char(it.path_byte);
      if (it.end_of_path && in_path) begin
        if (err_code == ErrNone) close_component();
        in_path = 1'b0;
      end
    end
    r.status      = (err_code != ErrNone) ? err_code :
                    (in_path ? apn_pkg::StBusy : apn_pkg::StDone);
    r.norm_length = norm_len[7:0];
    return r;
  endfunction

  function automatic void check_field(string field, logic [7:0] exp_val, logic [7:0] got_val);
    if (got_val !== exp_val) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_val, got_val);
    end
  endfunction

  // monitor: result transfers first, then configuration, then requests
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_len      = 1;
      norm_bytes[0] = apn_pkg::CharSlash;
      comp_dots     = 2'd0;
      err_code      = ErrNone;
      in_path       = 1'b0;
      capacity      = 9'd256;
      awaited_q.delete();
      mismatches    = 0;
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (awaited_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got status %0d length %0d data %0d",
                   $time, rsp_if.status, rsp_if.norm_length, rsp_if.read_data);
        end else begin
          want = awaited_q.pop_front();
          check_field("status", {6'd0, want.status}, {6'd0, rsp_if.status});
          check_field("norm_length", want.norm_length, rsp_if.norm_length);
          check_field("read_data", want.read_data, rsp_if.read_data);
        end
      end
      if (cfg_if.valid && cfg_if.ready) capacity = cfg_if.capacity_bytes;
      if (req_if.valid && req_if.ready) begin
        item.req_type    = req_if.req_type;
        item.path_byte   = req_if.path_byte;
        item.end_of_path = req_if.end_of_path;
        item.read_index  = req_if.read_index;
        awaited_q.push_back(normalize_item(item));
      end
      fail_count_o  <= mismatches;
      outstanding_o <= awaited_q.size();
    end
  end

endmodule

FILE: bench/tb_top.sv
// tb_top: testbench top of the absolute path normalizer
// drives directed and random paths, reads and capacity writes, and gives the verdict
// depends on apn_pkg, the channel interfaces, absolute_path_normalizer and apn_checker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BufBytes = 256;
  localparam int NumPhases = 9;
  localparam int PhaseItems = 18;
  localparam int HoldPhase = 4;
  localparam int HoldCycles = 300;
  localparam int EndCycles = 64;
  localparam int unsigned CycleLimit = 1000000;

  logic clk_i = 1'b0;
  logic rst_ni;

  apn_req_if req_if ();
  apn_rsp_if rsp_if ();
  apn_cfg_if cfg_if ();

  int fail_count;
  int outstanding;
  int items_sent;
  int hold_requests;
  int holds_done;
  bit send_fast;
  bit recv_fast;
  int unsigned cycle_count = 0;

  logic [8:0] phase_caps [NumPhases] = '{9'd256, 9'd2, 9'd1, 9'd3, 9'd511, 9'd0, 9'd24,
                                          9'd128, 9'd256};

  absolute_path_normalizer #(
    .BUF_BYTES (BufBytes)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_if (req_if),
    .rsp_if (rsp_if),
    .cfg_if (cfg_if)
  );

  apn_checker #(
    .BUF_BYTES (BufBytes)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_if        (req_if),
    .rsp_if        (rsp_if),
    .cfg_if        (cfg_if),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count == CycleLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // one request transfer, preceded by a random gap
  task automatic send_item(logic rq, logic [7:0] b, logic e, logic [7:0] idx);
    int gap;
    gap = send_fast ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.req_type    <= rq;
    req_if.path_byte   <= b;
    req_if.end_of_path <= e;
    req_if.read_index  <= idx;
    do @(posedge clk_i); while (!req_if.ready);
    items_sent++;
  endtask

  task automatic send_push(logic [7:0] b, logic e);
    send_item(apn_pkg::ReqPush, b, e, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_read(logic [7:0] idx);
    send_item(apn_pkg::ReqRead, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), idx);
  endtask

  task automatic send_str(string s, logic end_last);
    for (int i = 0; i < s.len(); i++) send_push(s[i], end_last && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] name_char();
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(1, 255));
    return 8'($urandom_range(8'h61, 8'h7a));
  endfunction

  // mostly well-formed path with random components, some noise and broken ends
  task automatic send_random_path();
    logic [7:0] path_chars [$];
    int ncomp;
    int end_mode;
    int last;
    ncomp    = $urandom_range(0, 6);
    end_mode = $urandom_range(0, 9);
    if ($urandom_range(0, 15) == 0) path_chars.push_back(8'($urandom_range(1, 255)));
    else repeat ($urandom_range(1, 2)) path_chars.push_back(apn_pkg::CharSlash);
    for (int k = 0; k < ncomp; k++) begin
      case ($urandom_range(0, 9))
        0: path_chars.push_back(apn_pkg::CharDot);
        1, 2: repeat (2) path_chars.push_back(apn_pkg::CharDot);
        3: repeat (3) path_chars.push_back(apn_pkg::CharDot);
        default: repeat ($urandom_range(1, 10)) path_chars.push_back(name_char());
      endcase
      if (k != ncomp - 1 || $urandom_range(0, 1) == 1)
        repeat ($urandom_range(1, 3)) path_chars.push_back(apn_pkg::CharSlash);
    end
    if ($urandom_range(0, 7) == 0)
      path_chars.insert($urandom_range(0, path_chars.size()), 8'($urandom_range(0, 255)));
    last = path_chars.size() - 1;
    foreach (path_chars[i]) begin
      if ($urandom_range(0, 9) == 0)
        send_read(($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 31)) :
                                                8'($urandom_range(0, 255)));
      send_push(path_chars[i], (end_mode > 2) && (i == last));
    end
    // flag-only end; end_mode 0 leaves the path open so the next one runs on
    if (end_mode == 1 || end_mode == 2) send_push(apn_pkg::CharNul, 1'b1);
  endtask

  // lower valid and wait until every expected result has come back
  task automatic drain();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic write_capacity(logic [8:0] v);
    cfg_if.valid          <= 1'b1;
    cfg_if.capacity_bytes <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // result side: random stalls, no-stall stretches and one long hold-off
  initial begin
    int stall;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_requests != holds_done) begin
        rsp_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        holds_done++;
      end
      if ($urandom_range(0, 31) == 0) recv_fast = !recv_fast;
      stall = recv_fast ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid && hold_requests == holds_done);
    end
  end

  // request side and verdict
  initial begin
    int phase;
    int phase_start;
    rst_ni                <= 1'b0;
    req_if.valid          <= 1'b0;
    req_if.req_type       <= apn_pkg::ReqPush;
    req_if.path_byte      <= apn_pkg::CharNul;
    req_if.end_of_path    <= 1'b0;
    req_if.read_index     <= 8'd0;
    cfg_if.valid          <= 1'b0;
    cfg_if.capacity_bytes <= 9'd0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, on the capacity from reset
    send_read(8'd0);
    send_read(8'hFF);
    // not absolute, bytes ignored under the sticky error, flag-only end
    send_push(8'hFF, 1'b0);
    send_push(apn_pkg::CharSlash, 1'b0);
    send_push(apn_pkg::CharNul, 1'b1);
    // zero byte while idle does nothing, with the end mark it is an empty path
    send_push(apn_pkg::CharNul, 1'b0);
    send_push(apn_pkg::CharNul, 1'b1);
    // dot dropped, walk-back over a component and at the root
    send_str("/./a/../..", 1'b1);
    send_read(8'd0);
    send_read(8'd1);
    // three dots is an ordinary name
    send_str("/...", 1'b0);
    send_push(8'hFF, 1'b1);
    send_read(8'd4);

    // random phases, each on its own capacity
    for (phase = 0; phase < NumPhases; phase++) begin
      drain();
      write_capacity((phase == 7) ? 9'($urandom_range(2, 256)) : phase_caps[phase]);
      phase_start = items_sent;
      if (phase == HoldPhase) begin
        // keep offering while the result side holds off
        hold_requests++;
        send_fast = 1'b1;
        send_random_path();
        send_random_path();
      end
      while (items_sent - phase_start < PhaseItems) begin
        send_fast = ($urandom_range(0, 3) == 0);
        send_random_path();
      end
      if (phase == NumPhases - 1) begin
        // five long names, the last byte just fits under the capacity limit
        send_fast = 1'b0;
        send_push(apn_pkg::CharSlash, 1'b0);
        repeat (5) begin
          repeat (50) send_push(8'($urandom_range(8'h61, 8'h7a)), 1'b0);
          send_push(apn_pkg::CharSlash, 1'b0);
        end
        send_push(apn_pkg::CharNul, 1'b1);
      end
    end
    drain();
    repeat (EndCycles) @(posedge clk_i);

    if (fail_count == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
